FILE: sv/clp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_pkg
// shared types, command codes and the led pin-pair table for the
// charlieplexed led scanner
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int LedCount = 16;
  localparam int PinCount = 5;
  localparam int LedIdxW  = $clog2(LedCount);
  localparam int PinIdxW  = $clog2(PinCount);
  localparam int CmdW     = 3;

  localparam int SpareBit   = 2;
  localparam int BatteryBit = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 3'd0,
    CMD_SET_MASK = 3'd1,
    CMD_SET_BATT = 3'd2,
    CMD_START    = 3'd3,
    CMD_STOP     = 3'd4
  } cmd_t;

  // anode and cathode pin of each led
  localparam logic [PinIdxW-1:0] ANODE_PIN [LedCount] = '{
    3'd0, 3'd1, 3'd1, 3'd3, 3'd2, 3'd2, 3'd4, 3'd4,
    3'd2, 3'd0, 3'd2, 3'd3, 3'd3, 3'd0, 3'd1, 3'd3
  };
  localparam logic [PinIdxW-1:0] CATHODE_PIN [LedCount] = '{
    3'd1, 3'd0, 3'd2, 3'd2, 3'd4, 3'd0, 3'd2, 3'd3,
    3'd3, 3'd2, 3'd1, 3'd4, 3'd0, 3'd3, 3'd3, 3'd1
  };

  typedef struct packed {
    logic [LedCount-1:0] display_bits;
    logic                battery_flag;
    logic [LedIdxW-1:0]  scan_position;
    logic                running;
    logic [PinCount-1:0] pins_high;
    logic [PinCount-1:0] pins_low;
  } scan_state_t;

  typedef struct packed {
    logic                found;
    logic [LedIdxW-1:0]  idx;
    logic [PinCount-1:0] pins_high;
    logic [PinCount-1:0] pins_low;
  } led_sel_t;

endpackage

FILE: sv/clp_next_led.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_next_led
// round-robin search for the next set mask bit after the scan position,
// and pin drive lookup for that led
// ----------------------------------------------------------------------------
module clp_next_led (
  input  logic [clp_pkg::LedCount-1:0] mask,
  input  logic [clp_pkg::LedIdxW-1:0]  position,
  output clp_pkg::led_sel_t            sel
);

  logic [clp_pkg::LedIdxW-1:0]  start_idx;
  logic [clp_pkg::LedCount-1:0] rot_mask;
  logic [clp_pkg::LedIdxW-1:0]  offset;
  logic [clp_pkg::LedIdxW-1:0]  led_idx;

  // rotate so that bit 0 is the position just after the current one
  assign start_idx = position + clp_pkg::LedIdxW'(1);
  assign rot_mask  = (mask >> start_idx) | (mask << (clp_pkg::LedIdxW'(clp_pkg::LedCount - 1)
                     - start_idx + clp_pkg::LedIdxW'(1)));

  // lowest set bit wins
  always_comb begin
    offset = '0;
    for (int i = clp_pkg::LedCount - 1; i >= 0; i--) begin
      if (rot_mask[i]) begin
        offset = clp_pkg::LedIdxW'(i);
      end
    end
  end

  assign led_idx = start_idx + offset;

  always_comb begin
    sel.found     = |mask;
    sel.idx       = led_idx;
    sel.pins_high = clp_pkg::PinCount'(1) << clp_pkg::ANODE_PIN[led_idx];
    sel.pins_low  = clp_pkg::PinCount'(1) << clp_pkg::CATHODE_PIN[led_idx];
  end

endmodule

FILE: sv/clp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_step
// applies one command to the scanner state and forms the next state
// ----------------------------------------------------------------------------
module clp_step (
  input  logic [clp_pkg::CmdW-1:0]     command,
  input  logic [clp_pkg::LedCount-1:0] display_mask_in,
  input  logic                         battery_in,
  input  clp_pkg::scan_state_t         cur,
  output clp_pkg::scan_state_t         nxt
);

  logic [clp_pkg::LedCount-1:0] lit_mask;
  logic [clp_pkg::LedCount-1:0] strip_mask;
  clp_pkg::led_sel_t            sel;

  always_comb begin
    lit_mask = cur.display_bits;
    if (cur.battery_flag) begin
      lit_mask[clp_pkg::BatteryBit] = 1'b1;
    end
    strip_mask = '1;
    strip_mask[clp_pkg::SpareBit]   = 1'b0;
    strip_mask[clp_pkg::BatteryBit] = 1'b0;
  end

  clp_next_led u_next_led (
    .mask     (lit_mask),
    .position (cur.scan_position),
    .sel      (sel)
  );

  always_comb begin
    nxt = cur;
    case (clp_pkg::cmd_t'(command))
      clp_pkg::CMD_TICK: begin
        if (cur.running) begin
          nxt.pins_high = '0;
          nxt.pins_low  = '0;
          if (sel.found) begin
            nxt.scan_position = sel.idx;
            nxt.pins_high     = sel.pins_high;
            nxt.pins_low      = sel.pins_low;
          end
        end
      end
      clp_pkg::CMD_SET_MASK: begin
        nxt.display_bits = display_mask_in & strip_mask;
      end
      clp_pkg::CMD_SET_BATT: begin
        nxt.battery_flag = battery_in;
      end
      clp_pkg::CMD_START: begin
        nxt.scan_position = '0;
        nxt.running       = 1'b1;
      end
      clp_pkg::CMD_STOP: begin
        nxt.running   = 1'b0;
        nxt.pins_high = '0;
        nxt.pins_low  = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

FILE: sv/charlieplex_led_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charlieplex_led_scanner
// scan driver for 16 charlieplexed leds on 5 tri-state pins
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one command per transfer:
//   tick, set display mask, set battery flag, start or stop
//   every input transfer yields exactly one result transfer on the output
//   channel (out_valid / out_stall) with the pin drive after that command
//   out_valid rises once the command has passed the input register, then the
//   result register; throughput: one command per cycle while the receiver does
//   not stall, with the next-led search and state update combinational between the registers
//   reset (rst_n low, synchronous) clears the mask, battery flag, scan
//   position and pin drive, stops the scan and empties both registers
//   when the receiver stalls, the result register holds its value; the
//   input register still takes one more command and then in_stall rises
//   until the result is taken
// ----------------------------------------------------------------------------
module charlieplex_led_scanner (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [clp_pkg::CmdW-1:0]     in_command,
  input  logic [clp_pkg::LedCount-1:0] in_display_mask_in,
  input  logic                         in_battery_in,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [clp_pkg::PinCount-1:0] out_drive_high,
  output logic [clp_pkg::PinCount-1:0] out_drive_low,
  output logic [clp_pkg::LedIdxW-1:0]  out_lit_index,
  output logic                         out_lit
);

  // input register
  logic                         s1_valid_r;
  logic [clp_pkg::CmdW-1:0]     s1_command_r;
  logic [clp_pkg::LedCount-1:0] s1_mask_r;
  logic                         s1_battery_r;

  // scanner state
  clp_pkg::scan_state_t state_r;
  clp_pkg::scan_state_t state_nxt;

  // result register
  logic                         out_valid_r;
  logic [clp_pkg::PinCount-1:0] out_high_r;
  logic [clp_pkg::PinCount-1:0] out_low_r;
  logic [clp_pkg::LedIdxW-1:0]  out_idx_r;

  logic out_free;
  logic s1_advance;
  logic in_xfer;

  // result slot is free when empty or being taken this cycle
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && out_free;
  assign in_stall   = s1_valid_r && !out_free;
  assign in_xfer    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_command_r <= in_command;
      s1_mask_r    <= in_display_mask_in;
      s1_battery_r <= in_battery_in;
    end
  end

  clp_step u_step (
    .command         (s1_command_r),
    .display_mask_in (s1_mask_r),
    .battery_in      (s1_battery_r),
    .cur             (state_r),
    .nxt             (state_nxt)
  );

  // state moves only when the command's result goes into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_high_r <= state_nxt.pins_high;
      out_low_r  <= state_nxt.pins_low;
      out_idx_r  <= state_nxt.scan_position;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_high = out_high_r;
  assign out_drive_low  = out_low_r;
  assign out_lit_index  = out_idx_r;
  assign out_lit        = |out_high_r;

  // at most one anode and one cathode, never the same pin
  a_pins_legal: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(state_r.pins_high) && $onehot0(state_r.pins_low)
      && ((state_r.pins_high & state_r.pins_low) == '0))
    else $error("illegal pin drive pattern");

  // a stopped scanner leaves every pin released
  a_stopped_released: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.running |-> (state_r.pins_high == '0 && state_r.pins_low == '0))
    else $error("pins driven while stopped");

  // input is held off only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid_r))
    else $error("input stalled without cause");

  // state changes only with a command moving into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_advance |=> $stable(state_r))
    else $error("state changed without a command");

endmodule

FILE: tb/led_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_scan_checker
// tracks the scanner state from every accepted command, predicts the pin
// drive that each command leaves behind and checks the result transfers
// against those predictions in order
// ----------------------------------------------------------------------------
module led_scan_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [clp_pkg::CmdW-1:0]     in_command,
  input  logic [clp_pkg::LedCount-1:0] in_display_mask_in,
  input  logic                         in_battery_in,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [clp_pkg::PinCount-1:0] out_drive_high,
  input  logic [clp_pkg::PinCount-1:0] out_drive_low,
  input  logic [clp_pkg::LedIdxW-1:0]  out_lit_index,
  input  logic                         out_lit,
  output int                           fail_count,
  output int                           pending
);
  import clp_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [PinCount-1:0] drive_high;
    logic [PinCount-1:0] drive_low;
    logic [LedIdxW-1:0]  lit_index;
    logic                lit;
  } pin_drive_t;

  // anode / cathode pin of each led position
  localparam logic [PinIdxW-1:0] LED_ANODE [LedCount] = '{
    3'd0, 3'd1, 3'd1, 3'd3, 3'd2, 3'd2, 3'd4, 3'd4,
    3'd2, 3'd0, 3'd2, 3'd3, 3'd3, 3'd0, 3'd1, 3'd3
  };
  localparam logic [PinIdxW-1:0] LED_CATHODE [LedCount] = '{
    3'd1, 3'd0, 3'd2, 3'd2, 3'd4, 3'd0, 3'd2, 3'd3,
    3'd3, 3'd2, 3'd1, 3'd4, 3'd0, 3'd3, 3'd3, 3'd1
  };

  // mirrored scanner state
  logic [LedCount-1:0] shown_mask = '0;
  logic                batt_on    = 1'b0;
  logic [LedIdxW-1:0]  scan_pos   = '0;
  logic                scanning   = 1'b0;
  logic [PinCount-1:0] hi_pins    = '0;
  logic [PinCount-1:0] lo_pins    = '0;

  pin_drive_t drive_q[$];
  pin_drive_t want;
  pin_drive_t got;
  pin_drive_t next_drive;
  int         results_seen = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // step to the next lit led after the current position, wrapping round
  task automatic advance_scan();
    logic [LedCount-1:0] active;
    logic [LedIdxW-1:0]  idx;
    logic [LedIdxW-1:0]  new_pos;
    logic                hit;
    active = shown_mask;
    if (batt_on) begin
      active[BatteryBit] = 1'b1;
    end
    hi_pins = '0;
    lo_pins = '0;
    hit     = 1'b0;
    new_pos = scan_pos;
    for (int k = 1; k <= LedCount; k++) begin
      idx = scan_pos + k[LedIdxW-1:0];
      if (!hit && active[idx]) begin
        hit     = 1'b1;
        new_pos = idx;
        hi_pins = PinCount'(1) << LED_ANODE[idx];
        lo_pins = PinCount'(1) << LED_CATHODE[idx];
      end
    end
    scan_pos = new_pos;
  endtask

  task automatic apply_command(input logic [CmdW-1:0] code,
                               input logic [LedCount-1:0] mask_in,
                               input logic bat, output pin_drive_t res);
    case (code)
      CMD_TICK: begin
        if (scanning) begin
          advance_scan();
        end
      end
      CMD_SET_MASK: begin
        shown_mask = mask_in;
        shown_mask[SpareBit]   = 1'b0;
        shown_mask[BatteryBit] = 1'b0;
      end
      CMD_SET_BATT: batt_on = bat;
      CMD_START: begin
        scan_pos = '0;
        scanning = 1'b1;
      end
      CMD_STOP: begin
        scanning = 1'b0;
        hi_pins  = '0;
        lo_pins  = '0;
      end
      default: ;
    endcase
    res.drive_high = hi_pins;
    res.drive_low  = lo_pins;
    res.lit_index  = scan_pos;
    res.lit        = (hi_pins != '0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // results first, so a stray early result never eats a fresh prediction
      if (out_valid && !out_stall) begin
        got.drive_high = out_drive_high;
        got.drive_low  = out_drive_low;
        got.lit_index  = out_lit_index;
        got.lit        = out_lit;
        if (drive_q.size() == 0) begin
          if (fail_count < ReportLimit) begin
            $display("unexpected result %0d: high=%b low=%b idx=%0d lit=%b",
                     results_seen, got.drive_high, got.drive_low,
                     got.lit_index, got.lit);
          end
          fail_count++;
        end else begin
          want = drive_q.pop_front();
          if (got !== want) begin
            if (fail_count < ReportLimit) begin
              $display("result %0d mismatch: expected high=%b low=%b idx=%0d lit=%b",
                       results_seen, want.drive_high, want.drive_low,
                       want.lit_index, want.lit);
              $display("  got high=%b low=%b idx=%0d lit=%b",
                       got.drive_high, got.drive_low, got.lit_index, got.lit);
            end
            fail_count++;
          end
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        apply_command(in_command, in_display_mask_in, in_battery_in, next_drive);
        drive_q.push_back(next_drive);
      end
      pending = drive_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// command stream and verdict for the charlieplexed led scanner; a directed
// walk through the scan corner cases, then a long random command mix under
// bursty sending and a patterned receiver stall, checked by led_scan_checker
// ----------------------------------------------------------------------------
module tb_top;
  import clp_pkg::*;

  localparam int NumRandom  = 1350;
  localparam int DrainLimit = 5000;
  // two register stages in the scanner, plus some margin
  localparam int TailCycles = 6;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                clk                = 1'b0;
  logic                rst_n              = 1'b0;
  logic                in_valid           = 1'b0;
  logic                in_stall;
  logic [CmdW-1:0]     in_command         = CMD_TICK;
  logic [LedCount-1:0] in_display_mask_in = '0;
  logic                in_battery_in      = 1'b0;
  logic                out_valid;
  logic                out_stall          = 1'b0;
  logic [PinCount-1:0] out_drive_high;
  logic [PinCount-1:0] out_drive_low;
  logic [LedIdxW-1:0]  out_lit_index;
  logic                out_lit;

  int fail_count;
  int pending;

  // sender burst bookkeeping
  int burst_left = 0;

  // receiver stall pattern state
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  always #6 clk = ~clk;

  charlieplex_led_scanner DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_display_mask_in (in_display_mask_in),
    .in_battery_in      (in_battery_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_high     (out_drive_high),
    .out_drive_low      (out_drive_low),
    .out_lit_index      (out_lit_index),
    .out_lit            (out_lit)
  );

  led_scan_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_display_mask_in (in_display_mask_in),
    .in_battery_in      (in_battery_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_high     (out_drive_high),
    .out_drive_low      (out_drive_low),
    .out_lit_index      (out_lit_index),
    .out_lit            (out_lit),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // receiver stall: the mode changes at random intervals, and the
  // no-stall mode gives long stretches where results drain at full rate
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((stall_tick % 11) < 4);
    endcase
  end

  // one command transfer; called at a rising edge, returns at the edge that
  // took it. a gap of idle cycles opens whenever the current burst runs out
  task automatic send_cmd(input logic [CmdW-1:0] code,
                          input logic [LedCount-1:0] mask,
                          input logic bat);
    logic go;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long unbroken one
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_command         <= code;
    in_display_mask_in <= mask;
    in_battery_in      <= bat;
    // stall is settled by the falling edge, so sample it there
    go = 1'b0;
    while (!go) begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end
  endtask

  function automatic logic [LedCount-1:0] pick_mask();
    logic [LedCount-1:0] one_hot;
    logic [LedIdxW-1:0]  hot_idx;
    hot_idx = LedIdxW'($urandom_range(0, LedCount - 1));
    one_hot = '0;
    one_hot[hot_idx] = 1'b1;
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return LedCount'($urandom & $urandom);
      4:       return one_hot | (LedCount'(1) << BatteryBit);
      default: return LedCount'($urandom);
    endcase
  endfunction

  // codes above stop are unused and must leave the state alone
  function automatic logic [CmdW-1:0] unused_code();
    return CmdW'(CMD_STOP + $urandom_range(1, 3));
  endfunction

  // weighted mix: mostly ticks while running so the scan walks far,
  // with mask, battery, start/stop changes and a little noise in between
  task automatic send_random_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      send_cmd(CMD_TICK, LedCount'($urandom), 1'($urandom));
    end else if (pick < 72) begin
      send_cmd(CMD_SET_MASK, pick_mask(), 1'($urandom));
    end else if (pick < 80) begin
      send_cmd(CMD_SET_BATT, LedCount'($urandom), 1'($urandom));
    end else if (pick < 88) begin
      send_cmd(CMD_START, LedCount'($urandom), 1'($urandom));
    end else if (pick < 94) begin
      send_cmd(CMD_STOP, LedCount'($urandom), 1'($urandom));
    end else begin
      send_cmd(unused_code(), LedCount'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int guard;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick while stopped changes nothing
    send_cmd(CMD_TICK, '0, 1'b0);
    send_cmd(CMD_START, '0, 1'b0);
    // running with an empty mask: pins stay released, position stays
    send_cmd(CMD_TICK, '0, 1'b0);
    // only the spare and battery bits set: stripped, so still empty
    send_cmd(CMD_SET_MASK, 16'h000C, 1'b1);
    send_cmd(CMD_TICK, '1, 1'b1);
    // all bits: stripped bits are skipped by the scan
    send_cmd(CMD_SET_MASK, '1, 1'b0);
    repeat (4) send_cmd(CMD_TICK, '0, 1'b0);
    // battery led alone: single led, scan wraps back onto itself
    send_cmd(CMD_SET_BATT, '0, 1'b1);
    send_cmd(CMD_SET_MASK, '0, 1'b0);
    repeat (2) send_cmd(CMD_TICK, '0, 1'b0);
    // top led plus battery: wrap from 15 to 3 and back
    send_cmd(CMD_SET_MASK, 16'h8000, 1'b0);
    repeat (3) send_cmd(CMD_TICK, '1, 1'b0);
    // restart while running: led stays lit, index reads 0
    send_cmd(CMD_START, '0, 1'b0);
    send_cmd(CMD_TICK, '0, 1'b0);
    // stop releases the pins and keeps the position
    send_cmd(CMD_STOP, '1, 1'b1);
    send_cmd(CMD_TICK, '0, 1'b0);
    send_cmd(CmdW'(CMD_STOP + 1), '1, 1'b1);
    send_cmd(CmdW'(CMD_STOP + 2), '0, 1'b0);
    send_cmd(CmdW'(CMD_STOP + 3), '1, 1'b1);
    send_cmd(CMD_SET_BATT, '1, 1'b0);
    send_cmd(CMD_SET_MASK, 16'h0001, 1'b0);
    send_cmd(CMD_START, '0, 1'b0);
    repeat (2) send_cmd(CMD_TICK, '0, 1'b0);

    repeat (NumRandom) send_random_cmd();

    in_valid <= 1'b0;

    // drain: wait for every predicted result, then TailCycles more so a
    // stray extra result would still be caught
    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while (pending != 0 && guard < DrainLimit);
    repeat (TailCycles) @(negedge clk);

    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
